/* hw/rtl/nmea_rmc_position_extractor_macros.svh */
// ----------------------------------------------------------------------------
// NMEA RMC position extractor assertion macros
// Shared assertion wrappers, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef NMEA_RMC_POSITION_EXTRACTOR_MACROS_SVH
`define NMEA_RMC_POSITION_EXTRACTOR_MACROS_SVH

// Immediate implication on the same edge.
`define NRMC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Implication on the following edge.
`define NRMC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/nrmc_pkg.sv */
// ----------------------------------------------------------------------------
// NMEA RMC position extractor package
// Byte codes, field indexes and shared state and result types.
// ----------------------------------------------------------------------------
package nrmc_pkg;

  localparam logic [7:0] ByteStart  = 8'h52;
  localparam logic [7:0] ByteCr     = 8'h0D;
  localparam logic [7:0] ByteLf     = 8'h0A;
  localparam logic [7:0] ByteTalker = 8'h4D;
  localparam logic [7:0] ByteComma  = 8'h2C;
  localparam logic [7:0] ByteActive = 8'h41;
  localparam logic [7:0] ByteNorth  = 8'h4E;
  localparam logic [7:0] ByteEast   = 8'h45;

  localparam logic [2:0] CommaStatus = 3'd2;
  localparam logic [2:0] CommaLat    = 3'd3;
  localparam logic [2:0] CommaLon    = 3'd5;
  localparam logic [2:0] CommaMax    = 3'd7;

  localparam logic FieldLat = 1'b0;
  localparam logic FieldLon = 1'b1;

  typedef struct packed {
    logic       capture_on;
    logic       at_line_start;
    logic       sentence_ok;
    logic [2:0] comma_count;
    logic       fix_valid;
  } line_state_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] ch;
    logic       fld;
    logic       last;
  } result_t;

endpackage

/* hw/rtl/nmea_rmc_position_extractor.sv */
// ----------------------------------------------------------------------------
// NMEA RMC position extractor
// Accepts one receiver byte per beat and returns latitude and longitude
// characters of valid RMC sentences, each closed by a hemisphere letter.
// Takes one byte every cycle while the output is not stalled, set by the
// single-pass step logic between an input register and a result register.
// A byte's result beat passes the input register and then the result register
// and can be taken when the output is not stalled. A stalled output holds the
// input register, which then stalls the input. No clearing pass after reset.
// ----------------------------------------------------------------------------
`include "nmea_rmc_position_extractor_macros.svh"

module nmea_rmc_position_extractor import nrmc_pkg::*; #(
  parameter int MAX_FIELD_CHARS = 12
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_char_o,
  output logic       which_field_o,
  output logic       field_last_o
);

  localparam int CntW = $clog2(MAX_FIELD_CHARS);

  logic            in_valid_q;
  logic [7:0]      rx_q;
  line_state_t     state_q, state_d;
  logic [CntW-1:0] chars_q, chars_d;
  result_t         result_d;
  logic            out_valid_q;
  logic [7:0]      out_char_q;
  logic            out_fld_q;
  logic            out_last_q;
  logic            out_free;
  logic            advance;

  assign out_free   = !out_valid_q || out_ready_i;
  assign advance    = in_valid_q && out_free;
  assign in_ready_o = !in_valid_q || out_free;

  nrmc_step #(
    .MAX_FIELD_CHARS(MAX_FIELD_CHARS)
  ) u_step (
    .rx_byte_i(rx_q),
    .state_i  (state_q),
    .chars_i  (chars_q),
    .state_o  (state_d),
    .chars_o  (chars_d),
    .result_o (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      rx_q <= rx_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{capture_on: 1'b0, at_line_start: 1'b1, sentence_ok: 1'b0,
                   comma_count: 3'd0, fix_valid: 1'b0};
      chars_q <= '0;
    end else if (advance) begin
      state_q <= state_d;
      chars_q <= chars_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= result_d.valid;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && result_d.valid) begin
      out_char_q <= result_d.ch;
      out_fld_q  <= result_d.fld;
      out_last_q <= result_d.last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_char_o    = out_char_q;
  assign which_field_o = out_fld_q;
  assign field_last_o  = out_last_q;

  `NRMC_ASSERT_NOW(a_last_letter, out_valid_o && field_last_o,
    (out_char_o == ByteNorth && which_field_o == FieldLat) ||
    (out_char_o == ByteEast && which_field_o == FieldLon),
    "closing beat carries wrong hemisphere letter")
  `NRMC_ASSERT_NOW(a_fix_needs_talker, state_q.fix_valid, state_q.sentence_ok,
    "fix flag set outside an RMC sentence")
  `NRMC_ASSERT_NOW(a_chars_bound, 1'b1, chars_q <= CntW'(MAX_FIELD_CHARS - 1),
    "field character count past its limit")
  `NRMC_ASSERT_NEXT(a_result_loaded, advance && result_d.valid,
    out_valid_o && out_char_o == $past(result_d.ch),
    "result not loaded into output register")

endmodule

/* hw/rtl/nrmc_step.sv */
// ----------------------------------------------------------------------------
// NMEA RMC byte step
// Next line state, field character count and optional result for one byte.
// ----------------------------------------------------------------------------
module nrmc_step import nrmc_pkg::*; #(
  parameter int MAX_FIELD_CHARS = 12,
  localparam int CntW = $clog2(MAX_FIELD_CHARS)
) (
  input  logic [7:0]      rx_byte_i,
  input  line_state_t     state_i,
  input  logic [CntW-1:0] chars_i,
  output line_state_t     state_o,
  output logic [CntW-1:0] chars_o,
  output result_t         result_o
);

  localparam logic [CntW-1:0] CntMax = CntW'(MAX_FIELD_CHARS - 1);

  logic fix_now;

  always_comb begin
    state_o  = state_i;
    chars_o  = chars_i;
    result_o = '0;
    fix_now  = state_i.fix_valid;
    if (rx_byte_i == ByteStart) begin
      state_o.capture_on    = 1'b1;
      state_o.at_line_start = 1'b1;
      state_o.sentence_ok   = 1'b0;
      state_o.comma_count   = '0;
      state_o.fix_valid     = 1'b0;
      chars_o               = '0;
    end else if (!state_i.capture_on) begin
      state_o = state_i;
    end else if (rx_byte_i == ByteCr || rx_byte_i == ByteLf) begin
      state_o.capture_on    = 1'b0;
      state_o.at_line_start = 1'b1;
    end else if (state_i.at_line_start) begin
      state_o.at_line_start = 1'b0;
      state_o.sentence_ok   = (rx_byte_i == ByteTalker);
    end else if (!state_i.sentence_ok) begin
      state_o = state_i;
    end else if (rx_byte_i == ByteComma) begin
      if (state_i.comma_count != CommaMax) begin
        state_o.comma_count = state_i.comma_count + 3'd1;
      end
      chars_o = '0;
      if (state_i.fix_valid && state_i.comma_count == CommaLat) begin
        result_o = '{valid: 1'b1, ch: ByteNorth, fld: FieldLat, last: 1'b1};
      end else if (state_i.fix_valid && state_i.comma_count == CommaLon) begin
        result_o = '{valid: 1'b1, ch: ByteEast, fld: FieldLon, last: 1'b1};
      end
    end else begin
      if (state_i.comma_count == CommaStatus && chars_i == '0) begin
        fix_now = (rx_byte_i == ByteActive);
      end
      state_o.fix_valid = fix_now;
      if (chars_i < CntMax) begin
        chars_o = chars_i + CntW'(1);
        if (fix_now && (state_i.comma_count == CommaLat ||
                        state_i.comma_count == CommaLon)) begin
          result_o.valid = 1'b1;
          result_o.ch    = rx_byte_i;
          result_o.fld   = (state_i.comma_count == CommaLon);
          result_o.last  = 1'b0;
        end
      end
    end
  end

endmodule
